[rtl/core/crp_pkg.sv]
package crp_pkg;

   localparam int IO_BITS                 = 24;
   localparam int IO_WIDTH                = 25;
   localparam int LQ                      = 30;
   localparam int N_WIDTH                 = 16;
   localparam int N_FRAC                  = 12;
   localparam int TAB_WIDTH               = 32;
   localparam int LANES                   = 2;
   localparam int CSR_INDEX_WIDTH         = 2;
   localparam int CSR_DATA_WIDTH          = 24;
   localparam int FRAC_BITS_DEFAULT       = 24;
   localparam int LOG_TABLE_DEPTH_DEFAULT = 256;

   localparam logic [63:0]         LONE   = 64'd1 << LQ;
   localparam logic [IO_WIDTH-1:0] ONE_IO = IO_WIDTH'(1) << IO_BITS;

   localparam logic                WET_RESET      = 1'b1;
   localparam logic [IO_BITS-1:0]  RESIDUAL_RESET = 24'd838861;
   localparam logic [N_WIDTH-1:0]  EXPONENT_RESET = 16'd12288;

   typedef enum logic [1:0] {
      SK_NORMAL,
      SK_LOW,
      SK_HIGH
   } sat_kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WETTING  = 2'd0,
      CSR_RESIDUAL = 2'd1,
      CSR_EXPONENT = 2'd2
   } csr_index_type;

   typedef enum logic {
      TAB_LOG,
      TAB_EXP
   } tab_kind_type;

   typedef struct packed {
      logic                wet;
      logic [IO_BITS-1:0]  residual;
      logic [N_WIDTH-1:0]  exponent;
   } cfg_type;

endpackage

[rtl/core/crp_rom.sv]
module crp_rom import crp_pkg::*; #(
   parameter int           LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEFAULT,
   parameter tab_kind_type TAB_KIND        = TAB_LOG,
   localparam int          IW              = $clog2(LOG_TABLE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [IW-1:0]        idx,
   output logic [TAB_WIDTH-1:0] data0,
   output logic [TAB_WIDTH-1:0] data1
);

   function automatic logic [63:0] isqrt64(input logic [63:0] vin);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = vin;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (b > v) b = b >> 2;
      end
      for (int j = 0; j < 32; j++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] log2_exact(input logic [63:0] xin);
      logic [63:0] x;
      logic [63:0] y;
      x = xin;
      y = 64'd0;
      if (x >= 64'd2 * LONE) begin
         y = LONE;
         x = x >> 1;
      end
      for (int k = LQ - 1; k >= 0; k--) begin
         x = (x * x) >> LQ;
         if (x >= 64'd2 * LONE) begin
            x = x >> 1;
            y = y | (64'd1 << k);
         end
      end
      return y;
   endfunction

   function automatic logic [63:0] exp_entry(input logic [63:0] t);
      logic [63:0] roots [LQ+1];
      logic [63:0] x;
      roots[0] = 64'd2 * LONE;
      for (int k = 1; k <= LQ; k++) roots[k] = isqrt64(roots[k-1] << LQ);
      x = LONE;
      for (int k = 1; k <= LQ; k++) begin
         if (((t >> (LQ - k)) & 64'd1) != 64'd0) x = (x * roots[k]) >> LQ;
      end
      return x;
   endfunction

   logic [TAB_WIDTH-1:0] rom [LOG_TABLE_DEPTH+1];
   logic [IW-1:0]        idx_next;

   for (genvar i = 0; i <= LOG_TABLE_DEPTH; i++) begin : g_entry
      localparam logic [63:0] T = (64'(i) << LQ) / LOG_TABLE_DEPTH;
      localparam logic [63:0] E = (TAB_KIND == TAB_LOG) ? log2_exact(LONE + T) :
                                  ((i == LOG_TABLE_DEPTH) ? 64'd2 * LONE : exp_entry(T));
      assign rom[i] = E[TAB_WIDTH-1:0];
   end

   assign idx_next = idx + IW'(1);

   always_ff @(posedge clock) begin
      if (en) begin
         data0 <= rom[idx];
         data1 <= rom[idx_next];
      end
   end

endmodule

[rtl/core/crp_div.sv]
module crp_div import crp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cfg_type                            cfg,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [IO_WIDTH-1:0]                in_one,
   input  logic [IO_WIDTH-1:0]                in_two,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [LANES-1:0][FRAC_BITS-1:0]    out_sat
);

   localparam int F  = FRAC_BITS;
   localparam int W  = F + 1;
   localparam int NS = F + 2;
   localparam logic [63:0]  ONE64 = 64'd1 << F;
   localparam logic [63:0]  EPS64 = (ONE64 + 64'd500000) / 64'd1000000;
   localparam logic [F:0]   ONE   = W'(ONE64);
   localparam logic [F-1:0] EPS   = F'(EPS64);
   localparam logic [F-1:0] HI    = F'(ONE64 - EPS64);

   logic [IO_WIDTH-1:0]     a_io;
   logic [IO_WIDTH+F-1:0]   a_wide;
   logic [IO_BITS+F-1:0]    sr_wide;
   logic [F:0]              a;
   logic [F:0]              sr;
   logic [F:0]              den;
   sat_kind_type            kind_in;

   logic [NS-1:0]           vld_ff;
   logic [NS:0]             en;
   logic [F:0]              rem_ff  [F+1];
   logic [F-1:0]            quo_ff  [F+1];
   sat_kind_type            kind_ff [F+1];
   logic [F:0]              rem_in  [F+1];
   logic [F-1:0]            quo_in  [F+1];
   logic [F-1:0]            sat_in;
   logic [LANES-1:0][F-1:0] sat_ff;

   assign a_io    = cfg.wet ? in_one : in_two;
   assign a_wide  = {a_io, F'(0)} >> IO_BITS;
   assign sr_wide = {cfg.residual, F'(0)} >> IO_BITS;
   assign a       = a_wide[F:0];
   assign sr      = {1'b0, sr_wide[F-1:0]};
   assign den     = ONE - sr;

   always_comb begin
      if (a <= sr) begin
         kind_in = SK_LOW;
      end else if (a >= ONE) begin
         kind_in = SK_HIGH;
      end else begin
         kind_in = SK_NORMAL;
      end
   end

   always_comb begin
      en[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) en[k] = ~vld_ff[k] | en[k+1];
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NS-1];
   assign out_sat   = sat_ff;

   // one quotient bit per stage
   always_comb begin
      logic [F+1:0] r2;
      rem_in[0] = a - sr;
      quo_in[0] = '0;
      for (int k = 1; k <= F; k++) begin
         r2 = {rem_ff[k-1], 1'b0};
         if (r2 >= {1'b0, den}) begin
            rem_in[k] = W'(r2 - {1'b0, den});
            quo_in[k] = {quo_ff[k-1][F-2:0], 1'b1};
         end else begin
            rem_in[k] = r2[F:0];
            quo_in[k] = {quo_ff[k-1][F-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      case (kind_ff[F])
         SK_LOW:  sat_in = EPS;
         SK_HIGH: sat_in = HI;
         default: begin
            if (quo_ff[F] < EPS) begin
               sat_in = EPS;
            end else if (quo_ff[F] > HI) begin
               sat_in = HI;
            end else begin
               sat_in = quo_ff[F];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0]  <= rem_in[0];
         quo_ff[0]  <= quo_in[0];
         kind_ff[0] <= kind_in;
      end
      for (int k = 1; k <= F; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            kind_ff[k] <= kind_ff[k-1];
         end
      end
      if (en[NS-1]) begin
         sat_ff[0] <= sat_in;
         sat_ff[1] <= F'(ONE - {1'b0, sat_in});
      end
   end

endmodule

[rtl/core/crp_pow.sv]
module crp_pow import crp_pkg::*; #(
   parameter int FRAC_BITS       = FRAC_BITS_DEFAULT,
   parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [N_WIDTH-1:0]              exponent,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [LANES-1:0][FRAC_BITS-1:0] in_v,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [LANES-1:0][IO_WIDTH-1:0]  out_perm
);

   localparam int F   = FRAC_BITS;
   localparam int NS  = 10;
   localparam int IW  = $clog2(LOG_TABLE_DEPTH + 1);
   localparam int PW  = $clog2(F);
   localparam int FW  = $clog2(F + 1);
   localparam int NLW = FW + LQ;
   localparam int NEW = NLW + N_WIDTH - N_FRAC;
   localparam int QW  = NEW - LQ;
   localparam int SW  = QW + 2;
   localparam int PRW = LQ + IW;
   localparam int RW  = (F > LQ) ? TAB_WIDTH + F - LQ : TAB_WIDTH;
   localparam logic [63:0]   ONE64 = 64'd1 << F;
   localparam logic [63:0]   EPS64 = (ONE64 + 64'd500000) / 64'd1000000;
   localparam logic [RW-1:0] EPS   = RW'(EPS64);

   logic [NS-1:0] vld_ff;
   logic [NS:0]   en;

   logic [LANES-1:0][F-1:0]         v_ff;
   logic [LANES-1:0][PW-1:0]        p_in;
   logic [LANES-1:0][PW-1:0]        p_ff;
   logic [LANES-1:0][IW-1:0]        lidx_in;
   logic [LANES-1:0][LQ-1:0]        lrem_in;
   logic [LANES-1:0][IW-1:0]        lidx_ff;
   logic [LANES-1:0][LQ-1:0]        lrem_ff;
   logic [LANES-1:0][PW-1:0]        p1_ff;
   logic [LANES-1:0][TAB_WIDTH-1:0] lt0;
   logic [LANES-1:0][TAB_WIDTH-1:0] lt1;
   logic [LANES-1:0][LQ-1:0]        lrem2_ff;
   logic [LANES-1:0][PW-1:0]        p2_ff;
   logic [LANES-1:0][TAB_WIDTH-1:0] ldp_in;
   logic [LANES-1:0][TAB_WIDTH-1:0] ldp_ff;
   logic [LANES-1:0][TAB_WIDTH-1:0] lt0_ff;
   logic [LANES-1:0][PW-1:0]        p3_ff;
   logic [LANES-1:0][NLW-1:0]       nlog_in;
   logic [LANES-1:0][NLW-1:0]       nlog_ff;
   logic [LANES-1:0][NEW-1:0]       nexp_in;
   logic [LANES-1:0][NEW-1:0]       nexp_ff;
   logic [LANES-1:0][IW-1:0]        eidx_in;
   logic [LANES-1:0][LQ-1:0]        erem_in;
   logic [LANES-1:0][QW:0]          s_in;
   logic [LANES-1:0][IW-1:0]        eidx_ff;
   logic [LANES-1:0][LQ-1:0]        erem_ff;
   logic [LANES-1:0][QW:0]          s6_ff;
   logic [LANES-1:0][TAB_WIDTH-1:0] et0;
   logic [LANES-1:0][TAB_WIDTH-1:0] et1;
   logic [LANES-1:0][LQ-1:0]        erem7_ff;
   logic [LANES-1:0][QW:0]          s7_ff;
   logic [LANES-1:0][TAB_WIDTH-1:0] edp_in;
   logic [LANES-1:0][TAB_WIDTH-1:0] edp_ff;
   logic [LANES-1:0][TAB_WIDTH-1:0] et0_ff;
   logic [LANES-1:0][QW:0]          s8_ff;
   logic [LANES-1:0][IO_WIDTH-1:0]  perm_in;
   logic [LANES-1:0][IO_WIDTH-1:0]  perm_ff;

   always_comb begin
      en[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) en[k] = ~vld_ff[k] | en[k+1];
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NS-1];
   assign out_perm  = perm_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      crp_rom #(
         .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH),
         .TAB_KIND        (TAB_LOG)
      ) u_log_rom (
         .clock (clock),
         .en    (en[2]),
         .idx   (lidx_ff[l]),
         .data0 (lt0[l]),
         .data1 (lt1[l])
      );

      crp_rom #(
         .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH),
         .TAB_KIND        (TAB_EXP)
      ) u_exp_rom (
         .clock (clock),
         .en    (en[7]),
         .idx   (eidx_ff[l]),
         .data0 (et0[l]),
         .data1 (et1[l])
      );
   end

   // leading one of the incoming saturation
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         p_in[l] = '0;
         for (int b = 0; b < F; b++) begin
            if (in_v[l][b]) p_in[l] = PW'(b);
         end
      end
   end

   always_comb begin
      logic [F+LQ-1:0]          mw;
      logic [PRW-1:0]           prod;
      logic [TAB_WIDTH+LQ-1:0]  mp;
      logic [TAB_WIDTH-1:0]     lg;
      logic [FW-1:0]            fp;
      logic [NLW+N_WIDTH-1:0]   np;
      logic [LQ-1:0]            g;
      logic [LQ-1:0]            t;
      logic [PRW-1:0]           eprod;
      logic [TAB_WIDTH+LQ-1:0]  emp;
      logic [TAB_WIDTH-1:0]     x;
      logic [SW-1:0]            sum;
      logic [SW-1:0]            sh;
      logic [RW-1:0]            r;
      logic [RW+IO_BITS-1:0]    io;
      for (int l = 0; l < LANES; l++) begin
         // mantissa in [1,2), then table index and fraction
         mw         = {v_ff[l], LQ'(0)} >> p_ff[l];
         prod       = PRW'(mw[LQ-1:0]) * PRW'(LOG_TABLE_DEPTH);
         lidx_in[l] = prod[PRW-1:LQ];
         lrem_in[l] = prod[LQ-1:0];

         mp        = (lt1[l] - lt0[l]) * lrem2_ff[l];
         ldp_in[l] = mp[TAB_WIDTH+LQ-1:LQ];

         lg         = lt0_ff[l] + ldp_ff[l];
         fp         = FW'(F) - FW'(p3_ff[l]);
         nlog_in[l] = {fp, LQ'(0)} - NLW'(lg);

         np         = nlog_ff[l] * exponent;
         nexp_in[l] = np[NLW+N_WIDTH-1:N_FRAC];

         g          = nexp_ff[l][LQ-1:0];
         t          = LQ'(0) - g;
         s_in[l]    = {1'b0, nexp_ff[l][NEW-1:LQ]} + (QW+1)'(g != '0);
         eprod      = PRW'(t) * PRW'(LOG_TABLE_DEPTH);
         eidx_in[l] = eprod[PRW-1:LQ];
         erem_in[l] = eprod[LQ-1:0];

         emp       = (et1[l] - et0[l]) * erem7_ff[l];
         edp_in[l] = emp[TAB_WIDTH+LQ-1:LQ];

         x   = et0_ff[l] + edp_ff[l];
         sum = SW'(s8_ff[l]) + SW'(LQ);
         sh  = '0;
         if (sum >= SW'(F)) begin
            sh = sum - SW'(F);
            r  = (sh >= SW'(TAB_WIDTH)) ? '0 : RW'(x >> sh);
         end else begin
            r  = RW'(x) << (SW'(F) - sum);
         end
         if (r < EPS) r = EPS;
         io         = {r, IO_BITS'(0)} >> F;
         perm_in[l] = io[IO_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         v_ff <= in_v;
         p_ff <= p_in;
      end
      if (en[1]) begin
         lidx_ff <= lidx_in;
         lrem_ff <= lrem_in;
         p1_ff   <= p_ff;
      end
      if (en[2]) begin
         lrem2_ff <= lrem_ff;
         p2_ff    <= p1_ff;
      end
      if (en[3]) begin
         ldp_ff <= ldp_in;
         lt0_ff <= lt0;
         p3_ff  <= p2_ff;
      end
      if (en[4]) nlog_ff <= nlog_in;
      if (en[5]) nexp_ff <= nexp_in;
      if (en[6]) begin
         eidx_ff <= eidx_in;
         erem_ff <= erem_in;
         s6_ff   <= s_in;
      end
      if (en[7]) begin
         erem7_ff <= erem_ff;
         s7_ff    <= s6_ff;
      end
      if (en[8]) begin
         edp_ff <= edp_in;
         et0_ff <= et0;
         s8_ff  <= s7_ff;
      end
      if (en[9]) perm_ff <= perm_in;
   end

endmodule

[rtl/core/corey_relative_permeability_core.sv]
// Corey relative permeability, one two-phase cell per word.
// Request channel (req_valid/req_ready) carries both phase fractions;
// the response channel (rsp_valid/rsp_ready) returns both relative
// permeabilities, already routed to phase one and phase two.
// Config writes go in on csr_valid/csr_ready with csr_index/csr_data:
// 0 wetting bit, 1 residual saturation, 2 Corey exponent. csr_ready is
// always high; write only while no word is in flight.
// Throughput: one word per cycle, sustained while rsp_ready stays high.
// Words pass the one-bit-per-stage saturation divider followed by the
// ten-stage log2 / multiply / exp2 pipeline with its table reads.
// Reset clears every pipeline valid and loads the default config; the
// log2 and exp2 tables are constants, so no fill time after reset.
// Receiver stall: results wait in the output register, earlier bubbles
// close up, and req_ready drops only once every stage holds a word.
module corey_relative_permeability_core import crp_pkg::*; #(
   parameter int FRAC_BITS       = FRAC_BITS_DEFAULT,
   parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [IO_WIDTH-1:0]        req_phase_one_fraction,
   input  logic [IO_WIDTH-1:0]        req_phase_two_fraction,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [IO_WIDTH-1:0]        rsp_phase_one_perm,
   output logic [IO_WIDTH-1:0]        rsp_phase_two_perm,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type                            cfg_ff;
   cfg_type                            cfg_in;
   logic                               sat_valid;
   logic                               sat_ready;
   logic [LANES-1:0][FRAC_BITS-1:0]    sat;
   logic [LANES-1:0][IO_WIDTH-1:0]     perm;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WETTING:  cfg_in.wet      = csr_data[0];
            CSR_RESIDUAL: cfg_in.residual = csr_data[IO_BITS-1:0];
            CSR_EXPONENT: cfg_in.exponent = csr_data[N_WIDTH-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wet      <= WET_RESET;
         cfg_ff.residual <= RESIDUAL_RESET;
         cfg_ff.exponent <= EXPONENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crp_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_one    (req_phase_one_fraction),
      .in_two    (req_phase_two_fraction),
      .out_valid (sat_valid),
      .out_ready (sat_ready),
      .out_sat   (sat)
   );

   crp_pow #(
      .FRAC_BITS       (FRAC_BITS),
      .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
   ) u_pow (
      .clock     (clock),
      .reset     (reset),
      .exponent  (cfg_ff.exponent),
      .in_valid  (sat_valid),
      .in_ready  (sat_ready),
      .in_v      (sat),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_perm  (perm)
   );

   // lane 0 is the wetting phase
   assign rsp_phase_one_perm = cfg_ff.wet ? perm[0] : perm[1];
   assign rsp_phase_two_perm = cfg_ff.wet ? perm[1] : perm[0];

`ifndef SYNTH
   a_zero_exponent_gives_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cfg_ff.exponent == '0) |->
      (rsp_phase_one_perm == ONE_IO && rsp_phase_two_perm == ONE_IO))
      else $error("zero exponent did not give unit permeability");

   a_perm_floored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_phase_one_perm != '0 && rsp_phase_two_perm != '0))
      else $error("permeability below floor");

   a_perm_at_most_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_phase_one_perm <= ONE_IO && rsp_phase_two_perm <= ONE_IO))
      else $error("permeability above one");

   a_backpressure_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a waiting response");
`endif

endmodule
